// ===== hdl/rsur_pkg.sv =====
// Shared constants and control types for the range set union block.
package rsur_pkg;

  // Size of the presence map and of the value fields
  localparam int VALUE_COUNT = 128;
  localparam int VAL_W       = 7;
  localparam int POS_W       = (VALUE_COUNT > 1) ? $clog2(VALUE_COUNT) : 1;

  // Input command codes
  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic add;    // mark the range of the current input transfer
    logic start;  // prepare a scan of the map
    logic step;   // examine the next map position
    logic flush;  // emit the held run, or the empty result
  } rsur_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic step_blocked;  // a found run cannot leave yet
    logic at_end;        // scan sits on the last map position
    logic out_free;      // output register can take a result this cycle
  } rsur_sts_t;

endpackage

// ===== hdl/range_set_union_runs_core.sv =====
// Top level of the range set union block: controller plus datapath.
//
// Input channel (in_valid_i / in_stall_o): command_i = 0 adds the inclusive
// range range_low_i..range_high_i to a 128-entry presence map; a reversed
// range adds nothing. command_i = 1 finishes: the map is read from value 0
// upward and every maximal run of present values leaves as one transfer on
// the output channel, the final one with last_run_o set. An empty map gives
// a single transfer with empty_set_o set and zero run fields. The map is
// clear again once a finish completes.
// An add never stalls the input and the next item is taken right after it.
// A finish holds the input stalled through the scan of all VALUE_COUNT map
// positions, one per cycle while the output does not stall (shifted out of
// the map register), and through the final result. Each run is sent once
// the next run has been found, the last one at the end.
// Output channel (out_valid_o / out_stall_i): one output register; while the
// receiver stalls, the result holds and the scan pauses at the next run.
// Reset empties the map and the output register and returns to idle.
module range_set_union_runs_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       command_i,
  input  logic [rsur_pkg::VAL_W-1:0] range_low_i,
  input  logic [rsur_pkg::VAL_W-1:0] range_high_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [rsur_pkg::VAL_W-1:0] run_low_o,
  output logic [rsur_pkg::VAL_W-1:0] run_high_o,
  output logic                       last_run_o,
  output logic                       empty_set_o
);
  import rsur_pkg::*;

  rsur_cmd_t cmd;
  rsur_sts_t sts;

  // Sequence transfers and scans
  rsur_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .command_i  (command_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Hold the map and produce results
  rsur_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .range_low_i  (range_low_i),
    .range_high_i (range_high_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .run_low_o    (run_low_o),
    .run_high_o   (run_high_o),
    .last_run_o   (last_run_o),
    .empty_set_o  (empty_set_o)
  );

endmodule

// ===== hdl/rsur_dpath.sv =====
// Datapath: presence map, run scanner and output register.
module rsur_dpath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rsur_pkg::rsur_cmd_t   cmd_i,
  output rsur_pkg::rsur_sts_t   sts_o,
  input  logic [rsur_pkg::VAL_W-1:0] range_low_i,
  input  logic [rsur_pkg::VAL_W-1:0] range_high_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [rsur_pkg::VAL_W-1:0] run_low_o,
  output logic [rsur_pkg::VAL_W-1:0] run_high_o,
  output logic                  last_run_o,
  output logic                  empty_set_o
);
  import rsur_pkg::*;

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(VALUE_COUNT - 1);

  logic [VALUE_COUNT-1:0] map_q, map_d;
  logic [VALUE_COUNT-1:0] lo_mask, hi_mask;
  logic [POS_W-1:0]       pos_q, pos_d;
  logic [POS_W-1:0]       start_q, start_d;
  logic                   in_run_q, in_run_d;
  logic                   pend_v_q, pend_v_d;
  logic [POS_W-1:0]       pend_lo_q, pend_lo_d;
  logic [POS_W-1:0]       pend_hi_q, pend_hi_d;
  logic                   out_v_q, out_v_d;
  logic [VAL_W-1:0]       out_lo_q, out_lo_d;
  logic [VAL_W-1:0]       out_hi_q, out_hi_d;
  logic                   out_last_q, out_last_d;
  logic                   out_empty_q, out_empty_d;
  logic                   cur_bit, run_end, out_free, at_end, push_run;
  logic [POS_W-1:0]       run_lo;

  // Build the range mask: bits at or above low and at or below high
  assign lo_mask = {VALUE_COUNT{1'b1}} << range_low_i;
  assign hi_mask = ~(({VALUE_COUNT{1'b1}} << range_high_i) << 1);

  // Scan view of the current position
  assign cur_bit  = map_q[0];
  assign at_end   = (pos_q == LAST_POS);
  assign run_end  = cur_bit && (at_end || !map_q[1]);
  assign run_lo   = in_run_q ? start_q : pos_q;
  assign out_free = !out_v_q || !out_stall_i;
  assign push_run = cmd_i.step && run_end && pend_v_q;

  assign sts_o.step_blocked = run_end && pend_v_q && !out_free;
  assign sts_o.at_end       = at_end;
  assign sts_o.out_free     = out_free;

  // Map update, scanner and output register next state
  always_comb begin
    map_d       = map_q;
    pos_d       = pos_q;
    start_d     = start_q;
    in_run_d    = in_run_q;
    pend_v_d    = pend_v_q;
    pend_lo_d   = pend_lo_q;
    pend_hi_d   = pend_hi_q;
    out_v_d     = out_v_q && out_stall_i;
    out_lo_d    = out_lo_q;
    out_hi_d    = out_hi_q;
    out_last_d  = out_last_q;
    out_empty_d = out_empty_q;

    if (cmd_i.add) begin
      map_d = map_q | (lo_mask & hi_mask);
    end

    if (cmd_i.start) begin
      pos_d    = '0;
      in_run_d = 1'b0;
      pend_v_d = 1'b0;
    end

    // Advance one position; the map shifts down so it empties as it is read
    if (cmd_i.step) begin
      map_d    = map_q >> 1;
      pos_d    = pos_q + POS_W'(1);
      in_run_d = cur_bit && !run_end;
      if (cur_bit) begin
        start_d = run_lo;
      end
      if (run_end) begin
        pend_v_d  = 1'b1;
        pend_lo_d = run_lo;
        pend_hi_d = pos_q;
      end
    end

    // Send the previously held run on when a newer one turns up
    if (push_run) begin
      out_v_d     = 1'b1;
      out_lo_d    = VAL_W'(pend_lo_q);
      out_hi_d    = VAL_W'(pend_hi_q);
      out_last_d  = 1'b0;
      out_empty_d = 1'b0;
    end

    // Final result of a finish
    if (cmd_i.flush) begin
      out_v_d     = 1'b1;
      out_last_d  = 1'b1;
      out_empty_d = !pend_v_q;
      out_lo_d    = pend_v_q ? VAL_W'(pend_lo_q) : '0;
      out_hi_d    = pend_v_q ? VAL_W'(pend_hi_q) : '0;
      pend_v_d    = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q    <= '0;
      pos_q    <= '0;
      in_run_q <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      map_q    <= map_d;
      pos_q    <= pos_d;
      in_run_q <= in_run_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    start_q     <= start_d;
    pend_lo_q   <= pend_lo_d;
    pend_hi_q   <= pend_hi_d;
    out_lo_q    <= out_lo_d;
    out_hi_q    <= out_hi_d;
    out_last_q  <= out_last_d;
    out_empty_q <= out_empty_d;
  end

  assign out_valid_o = out_v_q;
  assign run_low_o   = out_lo_q;
  assign run_high_o  = out_hi_q;
  assign last_run_o  = out_last_q;
  assign empty_set_o = out_empty_q;

endmodule

// ===== hdl/rsur_ctrl.sv =====
// Controller: accepts transfers and sequences the scan of a finish.
module rsur_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                command_i,
  input  rsur_pkg::rsur_sts_t sts_i,
  output rsur_pkg::rsur_cmd_t cmd_o
);
  import rsur_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);

  // Issue datapath commands
  assign cmd_o.add   = accept && (command_i == CMD_ADD);
  assign cmd_o.start = accept && (command_i == CMD_FINISH);
  assign cmd_o.step  = (state_q == ST_SCAN) && !sts_i.step_blocked;
  assign cmd_o.flush = (state_q == ST_FLUSH) && sts_i.out_free;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_o.start) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (cmd_o.step && sts_i.at_end) state_d = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (cmd_o.flush) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
